// File: rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants for the counting semaphore with waiter table.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int TASK_W      = 8;
    localparam int COUNT_W     = 8;
    localparam int STATUS_W    = 3;
    localparam int MODE_W      = 2;
    localparam int WAIT_SLOTS_DEF = 8;
    // Most wakeups reported by one release-all request
    localparam int MAX_RESULTS = 8;
    localparam int RES_W       = $clog2(MAX_RESULTS);

    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

    typedef enum logic [MODE_W-1:0] {
        MODE_DOWN    = 2'd0,
        MODE_UP      = 2'd1,
        MODE_RELEASE = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED = 3'd0,
        ST_QUEUED  = 3'd1,
        ST_FULL    = 3'd2,
        ST_WOKEN   = 3'd3,
        ST_NONE    = 3'd4
    } status_t;

endpackage

// File: rtl/sem_ifs.sv
// ----------------------------------------------------------------------------
// sem_ifs
// Request and response channels: valid/ready with payload.
// ----------------------------------------------------------------------------
interface sem_req_if;
    logic                       valid;
    logic                       ready;
    logic [sem_pkg::MODE_W-1:0] mode;
    logic [sem_pkg::TASK_W-1:0] task_id;

    modport source (output valid, output mode, output task_id, input ready);
    modport sink   (input valid, input mode, input task_id, output ready);
endinterface

interface sem_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [sem_pkg::STATUS_W-1:0] status;
    logic [sem_pkg::TASK_W-1:0]   woken_task;
    logic                         last;

    modport source (output valid, output status, output woken_task, output last,
                    input ready);
    modport sink   (input valid, input status, input woken_task, input last,
                    output ready);
endinterface

// File: rtl/semaphore_with_waiter_table.sv
// ----------------------------------------------------------------------------
// semaphore_with_waiter_table
// Counting semaphore with a table of waiting task slots.
// ----------------------------------------------------------------------------
// Requests arrive one beat at a time on req (mode, task_id); responses leave
// on rsp (status, woken_task, last), with last set on the final beat a
// request causes. Down takes a unit or parks the task in the lowest free
// slot (table full if none). Up wakes the lowest occupied slot only when the
// count is zero, and always bumps the count (saturating at 255). Release-all
// empties the table, sets the count to 1 and wakes every waiter it held,
// lowest slot first, up to eight beats. Mode 3 is dropped with no response.
// Timing: a request is accepted in S_IDLE and dispatched in the next cycle.
// An up that wakes passes through S_WAKE, since the task id comes out of
// the slot memory's registered read. Release-all steps through S_REL_SCAN
// and S_REL_EMIT, one slot memory read per wakeup. A new request is taken
// while the last response still waits in the output register. Slot valid
// bits are flip-flops cleared by reset, so no clearing pass is needed; task
// ids live in the memory and are read only behind a set valid bit.
// ----------------------------------------------------------------------------
module semaphore_with_waiter_table #(
    parameter int WAIT_SLOTS = sem_pkg::WAIT_SLOTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    sem_req_if.sink      req,
    sem_rsp_if.source    rsp
);
    import sem_pkg::*;

    localparam int SLOT_W = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_WAKE,
        S_REL_SCAN,
        S_REL_EMIT
    } state_t;

    state_t                  state_reg;
    logic [MODE_W-1:0]       mode_reg;
    logic [TASK_W-1:0]       task_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [WAIT_SLOTS-1:0]   valid_reg;     // slot occupied
    logic [WAIT_SLOTS-1:0]   rel_mask_reg;  // waiters still to report on release
    logic [RES_W-1:0]        rel_n_reg;     // wakeups reported so far

    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [TASK_W-1:0]       out_task_reg;
    logic                    out_last_reg;

    // Slot search
    logic                    free_found, occ_found, rel_found;
    logic [SLOT_W-1:0]       free_idx, occ_idx, rel_idx;

    sem_prio #(.N(WAIT_SLOTS), .W(SLOT_W)) u_free_prio (
        .bits (~valid_reg),
        .found(free_found),
        .idx  (free_idx)
    );

    sem_prio #(.N(WAIT_SLOTS), .W(SLOT_W)) u_occ_prio (
        .bits (valid_reg),
        .found(occ_found),
        .idx  (occ_idx)
    );

    sem_prio #(.N(WAIT_SLOTS), .W(SLOT_W)) u_rel_prio (
        .bits (rel_mask_reg),
        .found(rel_found),
        .idx  (rel_idx)
    );

    // Slot memory access
    logic                    mem_wr_en, mem_rd_en;
    logic [SLOT_W-1:0]       mem_rd_addr;
    logic [TASK_W-1:0]       mem_rd_data;

    sem_mem #(.DEPTH(WAIT_SLOTS), .AW(SLOT_W)) u_mem (
        .clk    (clk),
        .wr_en  (mem_wr_en),
        .wr_addr(free_idx),
        .wr_data(task_reg),
        .rd_en  (mem_rd_en),
        .rd_addr(mem_rd_addr),
        .rd_data(mem_rd_data)
    );

    // Output register can take a new beat this cycle
    logic out_free;
    logic count_zero;
    logic rel_last;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign count_zero = (count_reg == '0);
    assign rel_last   = (rel_mask_reg == '0) || (rel_n_reg == RES_W'(MAX_RESULTS - 1));

    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = occ_idx;
        if (state_reg == S_DISPATCH)
        begin
            // Down parks the task when no unit is left and a slot is free
            mem_wr_en = (mode_reg == MODE_DOWN) && count_zero && free_found && out_free;
            mem_rd_en = (mode_reg == MODE_UP) && count_zero && occ_found;
        end
        else if (state_reg == S_REL_SCAN)
        begin
            mem_rd_en   = rel_found;
            mem_rd_addr = rel_idx;
        end
    end

    function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= COUNT_RESET;
            valid_reg     <= '0;
            rel_mask_reg  <= '0;
            rel_n_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        mode_reg  <= req.mode;
                        task_reg  <= req.task_id;
                        state_reg <= S_DISPATCH;
                    end
                end

                S_DISPATCH:
                begin
                    case (mode_reg)
                        MODE_DOWN:
                        begin
                            if (out_free)
                            begin
                                out_valid_reg <= 1'b1;
                                out_task_reg  <= '0;
                                out_last_reg  <= 1'b1;
                                if (!count_zero)
                                begin
                                    count_reg      <= count_reg - COUNT_W'(1);
                                    out_status_reg <= ST_GRANTED;
                                end
                                else if (free_found)
                                begin
                                    valid_reg[free_idx] <= 1'b1;
                                    out_status_reg      <= ST_QUEUED;
                                end
                                else
                                begin
                                    out_status_reg <= ST_FULL;
                                end
                                state_reg <= S_IDLE;
                            end
                        end

                        MODE_UP:
                        begin
                            if (count_zero && occ_found)
                            begin
                                // Read issued this cycle; beat goes out from S_WAKE
                                valid_reg[occ_idx] <= 1'b0;
                                count_reg          <= count_inc(count_reg);
                                state_reg          <= S_WAKE;
                            end
                            else if (out_free)
                            begin
                                count_reg      <= count_inc(count_reg);
                                out_valid_reg  <= 1'b1;
                                out_status_reg <= ST_NONE;
                                out_task_reg   <= '0;
                                out_last_reg   <= 1'b1;
                                state_reg      <= S_IDLE;
                            end
                        end

                        MODE_RELEASE:
                        begin
                            rel_mask_reg <= valid_reg;
                            rel_n_reg    <= '0;
                            valid_reg    <= '0;
                            count_reg    <= COUNT_RESET;
                            state_reg    <= S_REL_SCAN;
                        end

                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end

                S_WAKE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= ST_WOKEN;
                        out_task_reg   <= mem_rd_data;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end

                S_REL_SCAN:
                begin
                    if (rel_found)
                    begin
                        rel_mask_reg[rel_idx] <= 1'b0;
                        state_reg             <= S_REL_EMIT;
                    end
                    else if (out_free)
                    begin
                        // empty table on release
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= ST_NONE;
                        out_task_reg   <= '0;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end

                S_REL_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= ST_WOKEN;
                        out_task_reg   <= mem_rd_data;
                        out_last_reg   <= rel_last;
                        rel_n_reg      <= rel_n_reg + RES_W'(1);
                        state_reg      <= rel_last ? S_IDLE : S_REL_SCAN;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.woken_task = out_task_reg;
    assign rsp.last       = out_last_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_release_clears : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DISPATCH && mode_reg == MODE_RELEASE)
        |=> (valid_reg == '0 && count_reg == COUNT_RESET))
        else $error("release-all did not clear table and count");

    a_no_rw_overlap : assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en))
        else $error("slot memory read and write in the same cycle");

    a_single_beat_last : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_GRANTED || rsp.status == ST_QUEUED
                       || rsp.status == ST_FULL || rsp.status == ST_NONE))
        |-> rsp.last)
        else $error("single-beat response without last");

    a_wake_frees_slot : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DISPATCH && mode_reg == MODE_UP && count_zero && occ_found)
        |=> (!valid_reg[$past(occ_idx)] && state_reg == S_WAKE))
        else $error("woken slot still occupied");

endmodule

// File: rtl/sem_mem.sv
// ----------------------------------------------------------------------------
// sem_mem
// Task id store of the waiter table: one write port, one registered read.
// ----------------------------------------------------------------------------
module sem_mem #(
    parameter int DEPTH = sem_pkg::WAIT_SLOTS_DEF,
    parameter int AW    = 3
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [sem_pkg::TASK_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [sem_pkg::TASK_W-1:0] rd_data
);
    import sem_pkg::*;

    logic [TASK_W-1:0] mem [DEPTH];
    logic [TASK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/sem_prio.sv
// ----------------------------------------------------------------------------
// sem_prio
// Lowest-set-bit finder: isolates the lowest one, then encodes it.
// ----------------------------------------------------------------------------
module sem_prio #(
    parameter int N = sem_pkg::WAIT_SLOTS_DEF,
    parameter int W = 3
) (
    input  logic [N-1:0] bits,
    output logic         found,
    output logic [W-1:0] idx
);
    logic [N-1:0] lowest;

    assign lowest = bits & (~bits + N'(1));
    assign found  = |bits;

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < N; i++)
        begin
            if (lowest[i])
            begin
                idx = idx | W'(i);
            end
        end
    end

endmodule

// File: bench/semaphore_with_waiter_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semaphore_with_waiter_table_test
// Self-checking bench for the counting semaphore with waiter table.
// ----------------------------------------------------------------------------
// Requests go in through one send task. Each accepted beat runs a local
// model of the count and the slot table, which queues the response beats
// the block must return. A monitor compares every accepted response beat
// with the oldest queued one, field by field. The tests run in sequence:
// directed corner cases, count saturation, a random mix, a stretch with no
// idling on either side, and a long receiver hold-off that backs the block
// up into its request port. A watchdog ends the run when no beat moves on
// either channel for too long.
// ----------------------------------------------------------------------------
module semaphore_with_waiter_table_test;
    import sem_pkg::*;

    localparam int SLOTS         = WAIT_SLOTS_DEF;
    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PCT      = 26;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 40;
    localparam int HOLD_CYCLES   = 300;
    // not a member of mode_t: the block drops it
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        status_t             status;
        logic [TASK_W-1:0]   woken_task;
        logic                last;
    } sem_result_t;

    logic clk;
    logic rst_n;

    sem_req_if req ();
    sem_rsp_if rsp ();

    semaphore_with_waiter_table #(
        .WAIT_SLOTS (SLOTS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // ------------------------------------------------------------------
    // Local model of the semaphore state
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] sem_count;
    logic               slot_busy [SLOTS];
    logic [TASK_W-1:0]  slot_task [SLOTS];

    // response beats still owed by the block, oldest first
    sem_result_t owed_results [$];

    int  fail_count;
    bit  idle_on;       // random idling on both sides
    int  hold_request;  // set by a test, taken up by the receiver process
    int  quiet_cycles;

    function automatic sem_result_t make_result(status_t st, logic [TASK_W-1:0] who,
                                                logic lst);
        sem_result_t r;
        r.status     = st;
        r.woken_task = who;
        r.last       = lst;
        return r;
    endfunction

    // Apply one accepted request to the model and queue its response beats.
    function automatic void model_request(logic [MODE_W-1:0] m, logic [TASK_W-1:0] tid);
        int  n;
        bit  woke;
        bit  placed;
        logic [TASK_W-1:0] who;
        n      = 0;
        woke   = 1'b0;
        placed = 1'b0;
        who    = '0;
        if (m == MODE_DOWN) begin
            if (sem_count != 0) begin
                sem_count = sem_count - 1'b1;
                owed_results.push_back(make_result(ST_GRANTED, '0, 1'b1));
            end
            else begin
                // park in the lowest free slot
                for (int i = 0; i < SLOTS; i++) begin
                    if (!placed && !slot_busy[i]) begin
                        slot_busy[i] = 1'b1;
                        slot_task[i] = tid;
                        placed       = 1'b1;
                    end
                end
                if (placed)
                    owed_results.push_back(make_result(ST_QUEUED, '0, 1'b1));
                else
                    owed_results.push_back(make_result(ST_FULL, '0, 1'b1));
            end
        end
        else if (m == MODE_UP) begin
            // a waiter is woken only when no unit is left
            if (sem_count == 0) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!woke && slot_busy[i]) begin
                        who          = slot_task[i];
                        slot_busy[i] = 1'b0;
                        woke         = 1'b1;
                    end
                end
            end
            if (sem_count != COUNT_MAX)
                sem_count = sem_count + 1'b1;
            if (woke)
                owed_results.push_back(make_result(ST_WOKEN, who, 1'b1));
            else
                owed_results.push_back(make_result(ST_NONE, '0, 1'b1));
        end
        else if (m == MODE_RELEASE) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_busy[i] && n < MAX_RESULTS) begin
                    owed_results.push_back(make_result(ST_WOKEN, slot_task[i], 1'b0));
                    n++;
                end
                slot_busy[i] = 1'b0;
            end
            sem_count = COUNT_RESET;
            if (n == 0)
                owed_results.push_back(make_result(ST_NONE, '0, 1'b1));
            else
                owed_results[owed_results.size() - 1].last = 1'b1;
        end
        // unused mode: no state change, no response
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Receiver: random ready, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                rsp.ready <= 1'b0;
                hold_left--;
            end
            else if (idle_on)
                rsp.ready <= ($urandom_range(99) >= IDLE_PCT);
            else
                rsp.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Response monitor: each accepted beat against the oldest owed beat
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sem_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (owed_results.size() == 0)
            begin
                $error("response beat with none owed: status %0d woken_task %0d last %0d",
                       rsp.status, rsp.woken_task, rsp.last);
                fail_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.woken_task !== want.woken_task)
                begin
                    $error("woken_task: expected %0d, actual %0d",
                           want.woken_task, rsp.woken_task);
                    fail_count++;
                end
                if (rsp.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, rsp.last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles in which no beat moves on either channel
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $error("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request beat and hold it until accepted; valid stays high
    // so the next call can follow back to back.
    task automatic send_request(logic [MODE_W-1:0] m, logic [TASK_W-1:0] tid);
        if (idle_on)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                req.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req.valid   <= 1'b1;
        req.mode    <= m;
        req.task_id <= tid;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        model_request(m, tid);
    endtask

    // Random request, biased so the count keeps reaching zero and the
    // table fills; a few beats use the dropped mode.
    task automatic send_random_request();
        int pick;
        logic [MODE_W-1:0] m;
        pick = $urandom_range(99);
        if (pick < 48)
            m = MODE_DOWN;
        else if (pick < 83)
            m = MODE_UP;
        else if (pick < 95)
            m = MODE_RELEASE;
        else
            m = MODE_UNUSED;
        send_request(m, TASK_W'($urandom));
    endtask

    // Lower valid and wait until every owed response beat has come back.
    task automatic wait_drained();
        req.valid <= 1'b0;
        @(posedge clk);
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Grant, queue, wake; up with units left wakes nobody even with a waiter.
    task automatic test_grant_and_wake();
        send_request(MODE_DOWN, 8'h3C);      // granted, count 0
        send_request(MODE_DOWN, 8'h00);      // queued in slot 0
        send_request(MODE_DOWN, 8'hFF);      // queued in slot 1
        send_request(MODE_UP, 8'h11);        // wakes 0x00, count 1
        send_request(MODE_UP, 8'h22);        // count 1: nothing woken, 0xFF stays
        send_request(MODE_DOWN, 8'h33);
        send_request(MODE_DOWN, 8'h44);      // count back to 0
        send_request(MODE_UP, 8'h55);        // wakes 0xFF
        wait_drained();
    endtask

    // Fill the table (same id twice), overflow it, release a full table,
    // then release an empty one, up with no waiter at count 0, unused mode.
    task automatic test_table_full_and_release();
        send_request(MODE_RELEASE, 8'h00);   // known start: count 1, table empty
        send_request(MODE_DOWN, 8'h01);
        send_request(MODE_DOWN, 8'hA5);
        send_request(MODE_DOWN, 8'hA5);
        for (int i = 0; i < SLOTS - 2; i++)
            send_request(MODE_DOWN, TASK_W'(8'h80 + i));
        send_request(MODE_DOWN, 8'h7F);      // table full
        send_request(MODE_RELEASE, 8'h5A);   // eight wakeups
        send_request(MODE_RELEASE, 8'hC3);   // nothing woken
        send_request(MODE_DOWN, 8'h10);
        send_request(MODE_UP, 8'h20);        // count 0, no waiter
        send_request(MODE_UNUSED, 8'hFF);    // dropped
        wait_drained();
    endtask

    // Enough ups to pin the count at its maximum, then back to one.
    task automatic test_count_saturation();
        for (int i = 0; i < 260; i++)
            send_request(MODE_UP, TASK_W'($urandom));
        send_request(MODE_DOWN, 8'h01);
        send_request(MODE_UP, 8'h02);
        send_request(MODE_UP, 8'h03);
        send_request(MODE_RELEASE, 8'h04);
        wait_drained();
    endtask

    task automatic test_random_mix(int n);
        for (int i = 0; i < n; i++)
            send_random_request();
        wait_drained();
    endtask

    // Neither side idles.
    task automatic test_back_to_back(int n);
        idle_on = 1'b0;
        for (int i = 0; i < n; i++)
            send_random_request();
        wait_drained();
        idle_on = 1'b1;
    endtask

    // Receiver holds off while requests keep coming, so the block backs up.
    task automatic test_receiver_hold(int n);
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < n; i++)
            send_random_request();
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        fail_count   = 0;
        idle_on      = 1'b1;
        hold_request = 0;
        quiet_cycles = 0;
        sem_count    = COUNT_RESET;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_busy[i] = 1'b0;
            slot_task[i] = '0;
        end
        rst_n       <= 1'b0;
        req.valid   <= 1'b0;
        req.mode    <= MODE_DOWN;
        req.task_id <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_grant_and_wake();
        test_table_full_and_release();
        test_count_saturation();
        test_random_mix(16);
        test_back_to_back(24);
        test_receiver_hold(10);
        test_random_mix(6);

        // let any stray beat show up after the last owed one
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
